/* design/spectrum_trace_averager_assert.svh */
// Assertion macros shared by the spectrum trace averager RTL.
`ifndef SPECTRUM_TRACE_AVERAGER_ASSERT_SVH
`define SPECTRUM_TRACE_AVERAGER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define STA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spectrum_trace_averager assertion failed");

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define STA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spectrum_trace_averager assertion failed");

`endif

/* design/sta_pkg.sv */
// Types and constants shared by the spectrum trace averager modules.
`default_nettype none
package sta_pkg;

    localparam int CNT_W  = 13;  // frame counts and divisor, up to 8191
    localparam int SUM_W  = 40;  // running sum width
    localparam int DVD_W  = 48;  // signed dividend width
    localparam int DCNT_W = 6;   // divider step counter
    localparam int CFG_W  = 11;  // widest configuration register

    localparam logic [2:0] MODE_PEAK     = 3'd0;
    localparam logic [2:0] MODE_MIN      = 3'd1;
    localparam logic [2:0] MODE_EXP_MSQ  = 3'd2;
    localparam logic [2:0] MODE_EXP_AVG  = 3'd3;
    localparam logic [2:0] MODE_WIN_PEAK = 3'd4;
    localparam logic [2:0] MODE_WIN_MIN  = 3'd5;
    localparam logic [2:0] MODE_MOV_MSQ  = 3'd6;
    localparam logic [2:0] MODE_MOV_AVG  = 3'd7;

    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_FRAME_BINS  = 2'd1;
    localparam logic [1:0] REG_HISTORY_LEN = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         bin_index;
        logic signed [31:0] trace_value;
        logic               last_bin;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_SUM,
        ST_DIV,
        ST_DIVOUT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ROUTE_DONE,
        ROUTE_SUM,
        ROUTE_SCAN
    } route_t;

    typedef struct packed {
        logic accept;
        logic clear;
        logic sq_load;
        logic eval;
        logic sum;
        logic div_step;
        logic div_out;
        logic scan_rd;
        logic scan_cmp;
        logic finish;
    } cmd_t;

    typedef struct packed {
        route_t route;
        logic   div_last;
        logic   scan_last;
        logic   out_free;
    } status_t;

endpackage
`default_nettype wire

/* design/sta_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                                   aclk,
    input  wire                                   we,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                      wdata,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

/* design/sta_ctrl.sv */
// Sequencing state machine for the spectrum trace averager.
`default_nettype none
module sta_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    input  wire              s_kind,
    input  sta_pkg::status_t status,
    output logic             s_ready,
    output sta_pkg::cmd_t    cmd
);

    sta_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sta_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sta_pkg::ST_IDLE: begin
                if (s_valid && s_kind == sta_pkg::KIND_SAMPLE) begin
                    state_next = sta_pkg::ST_READ;
                end
            end
            sta_pkg::ST_READ: state_next = sta_pkg::ST_EVAL;
            sta_pkg::ST_EVAL: begin
                case (status.route)
                    sta_pkg::ROUTE_SUM:  state_next = sta_pkg::ST_SUM;
                    sta_pkg::ROUTE_SCAN: state_next = sta_pkg::ST_SCAN_RD;
                    default:             state_next = sta_pkg::ST_FINISH;
                endcase
            end
            sta_pkg::ST_SUM: state_next = sta_pkg::ST_DIV;
            sta_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = sta_pkg::ST_DIVOUT;
                end
            end
            sta_pkg::ST_DIVOUT:  state_next = sta_pkg::ST_FINISH;
            sta_pkg::ST_SCAN_RD: state_next = sta_pkg::ST_SCAN_CMP;
            sta_pkg::ST_SCAN_CMP: begin
                state_next = status.scan_last ? sta_pkg::ST_FINISH : sta_pkg::ST_SCAN_RD;
            end
            sta_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = sta_pkg::ST_IDLE;
                end
            end
            default: state_next = sta_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == sta_pkg::ST_IDLE);
        cmd          = '0;
        cmd.accept   = s_ready && s_valid && (s_kind == sta_pkg::KIND_SAMPLE);
        cmd.clear    = s_ready && s_valid && (s_kind == sta_pkg::KIND_CLEAR);
        cmd.sq_load  = (state_reg == sta_pkg::ST_READ);
        cmd.eval     = (state_reg == sta_pkg::ST_EVAL);
        cmd.sum      = (state_reg == sta_pkg::ST_SUM);
        cmd.div_step = (state_reg == sta_pkg::ST_DIV);
        cmd.div_out  = (state_reg == sta_pkg::ST_DIVOUT);
        cmd.scan_rd  = (state_reg == sta_pkg::ST_SCAN_RD);
        cmd.scan_cmp = (state_reg == sta_pkg::ST_SCAN_CMP);
        cmd.finish   = (state_reg == sta_pkg::ST_FINISH) && status.out_free;
    end

endmodule
`default_nettype wire

/* design/sta_dpath.sv */
// Datapath: configuration, bin counters, trace stores, divider and window rescan.
`default_nettype none
module sta_dpath #(
    parameter int BINS_MAX    = 1024,
    parameter int HISTORY_MAX = 256
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_we,
    input  wire  [1:0]               cfg_index,
    input  wire  [sta_pkg::CFG_W-1:0] cfg_wdata,
    input  sta_pkg::in_item_t        s_payload,
    input  sta_pkg::cmd_t            cmd,
    input  wire                      m_ready,
    output sta_pkg::status_t         status,
    output logic                     m_valid,
    output sta_pkg::out_item_t       m_payload
);

    localparam int PW    = (BINS_MAX > 1) ? $clog2(BINS_MAX) : 1;
    localparam int SW    = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
    localparam int CW    = sta_pkg::CNT_W;
    localparam int DW    = sta_pkg::DVD_W;
    localparam int SUMW  = sta_pkg::SUM_W;

    logic [2:0]      mode_reg;
    logic [10:0]     fbins_reg;
    logic [8:0]      hlen_reg;
    logic [PW-1:0]   bin_pos_reg;
    logic [CW-1:0]   frames_reg;
    logic [SW-1:0]   wslot_reg;
    logic            m_valid_reg;

    logic [PW-1:0]          pos_reg;
    logic signed [15:0]     x_reg;
    logic signed [31:0]     sq_reg;
    logic signed [DW-1:0]   prod_reg;
    logic signed [31:0]     res_reg;
    logic [DW-1:0]          quo_reg;
    logic [CW:0]            rem_reg;
    logic [CW-1:0]          dvs_reg;
    logic                   neg_reg;
    logic [sta_pkg::DCNT_W-1:0] dcnt_reg;
    logic [SW-1:0]          j_reg;
    logic signed [15:0]     best_reg;
    sta_pkg::out_item_t     m_data_reg;

    logic [16:0]   fb17, f_eff, bp17;
    logic [CW-1:0] h13, h_eff, hm1, count;
    logic          first, full, want_max, last;
    logic [PW-1:0] pos_sel;

    logic [31:0]         res_rdata;
    logic [SUMW-1:0]     sum_rdata;
    logic [15:0]         ring_rdata;
    logic signed [31:0]  prev;
    logic signed [15:0]  old;
    logic [SW+PW-1:0]    ring_raddr, ring_waddr;
    logic                sum_we;

    // Effective frame length and history length after saturation.
    always_comb begin
        fb17 = 17'(fbins_reg);
        if (fb17 == 17'd0) begin
            f_eff = 17'd1;
        end else if (fb17 > 17'(BINS_MAX)) begin
            f_eff = 17'(BINS_MAX);
        end else begin
            f_eff = fb17;
        end
        h13 = CW'(hlen_reg);
        if (h13 == '0) begin
            h_eff = CW'(1);
        end else if (h13 > CW'(HISTORY_MAX)) begin
            h_eff = CW'(HISTORY_MAX);
        end else begin
            h_eff = h13;
        end
        hm1     = h_eff - CW'(1);
        first   = (frames_reg == '0);
        full    = (frames_reg >= h_eff);
        count   = full ? h_eff : frames_reg + CW'(1);
        bp17    = 17'(bin_pos_reg);
        pos_sel = (bp17 >= f_eff) ? PW'(f_eff - 17'd1) : bin_pos_reg;
        last    = (17'(pos_reg) + 17'd1 >= f_eff);
        want_max = (mode_reg == sta_pkg::MODE_WIN_PEAK);
    end

    assign prev = signed'(res_rdata);
    assign old  = signed'(ring_rdata);

    assign ring_raddr = cmd.scan_rd ? {j_reg, pos_reg} : {wslot_reg, pos_reg};
    assign ring_waddr = {wslot_reg, pos_reg};
    assign sum_we     = cmd.sum && (mode_reg inside {sta_pkg::MODE_MOV_MSQ,
                                                     sta_pkg::MODE_MOV_AVG});

    // Evaluation of the stored trace against the new sample.
    logic signed [31:0]   x32, ext, sq_w, old_w, old_sq;
    logic signed [DW-1:0] hm1_w, prev_w, prod_next;
    logic signed [31:0]   res_eval;
    logic                 better;
    sta_pkg::route_t      route;

    always_comb begin
        x32      = 32'(x_reg);
        better   = want_max ? (x32 > prev) : (x32 < prev);
        ext      = better ? x32 : prev;
        hm1_w    = DW'(signed'({1'b0, hm1}));
        prev_w   = DW'(prev);
        old_w    = 32'(old);
        old_sq   = old_w * old_w;
        sq_w     = sq_reg;
        prod_next = '0;
        res_eval = x32;
        route    = sta_pkg::ROUTE_DONE;
        case (mode_reg)
            sta_pkg::MODE_PEAK: begin
                res_eval = (first || x32 > prev) ? x32 : prev;
            end
            sta_pkg::MODE_MIN: begin
                res_eval = (first || x32 < prev) ? x32 : prev;
            end
            sta_pkg::MODE_EXP_MSQ, sta_pkg::MODE_EXP_AVG: begin
                res_eval  = (mode_reg == sta_pkg::MODE_EXP_MSQ) ? sq_w : x32;
                prod_next = hm1_w * prev_w;
                route     = first ? sta_pkg::ROUTE_DONE : sta_pkg::ROUTE_SUM;
            end
            sta_pkg::MODE_WIN_PEAK, sta_pkg::MODE_WIN_MIN: begin
                if (first || h_eff == CW'(1)) begin
                    res_eval = x32;
                end else begin
                    res_eval = ext;
                    if (full && old_w == ext) begin
                        route = sta_pkg::ROUTE_SCAN;
                    end
                end
            end
            sta_pkg::MODE_MOV_MSQ: begin
                prod_next = full ? DW'(old_sq) : '0;
                route     = sta_pkg::ROUTE_SUM;
            end
            default: begin
                prod_next = full ? DW'(old) : '0;
                route     = sta_pkg::ROUTE_SUM;
            end
        endcase
    end

    // Dividend formation for the averaging modes.
    logic signed [DW-1:0] add_w, base_w, dvd;
    always_comb begin
        add_w  = (mode_reg inside {sta_pkg::MODE_EXP_MSQ, sta_pkg::MODE_MOV_MSQ}) ?
                 DW'(sq_reg) : DW'(x_reg);
        base_w = first ? '0 : DW'(signed'(sum_rdata));
        if (mode_reg inside {sta_pkg::MODE_EXP_MSQ, sta_pkg::MODE_EXP_AVG}) begin
            dvd = add_w + prod_reg;
        end else begin
            dvd = base_w + add_w - prod_reg;
        end
    end

    // One restoring step per cycle on the magnitude.
    logic [CW:0]   rem_try;
    logic          rem_ge;
    always_comb begin
        rem_try = {rem_reg[CW-1:0], quo_reg[DW-1]};
        rem_ge  = (rem_try >= {1'b0, dvs_reg});
    end

    // Rescan compare.
    logic signed [15:0] best_next;
    logic               take;
    always_comb begin
        take = (j_reg != wslot_reg) &&
               (want_max ? (old > best_reg) : (old < best_reg));
        best_next = take ? old : best_reg;
    end

    assign status.route     = route;
    assign status.div_last  = (dcnt_reg == sta_pkg::DCNT_W'(DW - 1));
    assign status.scan_last = (CW'(j_reg) == hm1);
    assign status.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= sta_pkg::MODE_MOV_AVG;
            fbins_reg   <= 11'd1024;
            hlen_reg    <= 9'd1;
            bin_pos_reg <= '0;
            frames_reg  <= '0;
            wslot_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    sta_pkg::REG_MODE:        mode_reg  <= cfg_wdata[2:0];
                    sta_pkg::REG_FRAME_BINS:  fbins_reg <= cfg_wdata[10:0];
                    sta_pkg::REG_HISTORY_LEN: hlen_reg  <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if ((cfg_we && (cfg_index inside {sta_pkg::REG_MODE, sta_pkg::REG_FRAME_BINS,
                                              sta_pkg::REG_HISTORY_LEN})) || cmd.clear) begin
                bin_pos_reg <= '0;
                frames_reg  <= '0;
                wslot_reg   <= '0;
            end else if (cmd.finish) begin
                if (last) begin
                    bin_pos_reg <= '0;
                    if (frames_reg < h_eff) begin
                        frames_reg <= frames_reg + CW'(1);
                    end
                    wslot_reg <= (CW'(wslot_reg) + CW'(1) >= h_eff) ? '0 :
                                 wslot_reg + SW'(1);
                end else begin
                    bin_pos_reg <= pos_reg + PW'(1);
                end
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pos_reg <= pos_sel;
            x_reg   <= s_payload.sample;
        end
        if (cmd.sq_load) begin
            sq_reg <= 32'(x_reg) * 32'(x_reg);
        end
        if (cmd.eval) begin
            prod_reg <= prod_next;
            res_reg  <= res_eval;
            best_reg <= x_reg;
            j_reg    <= '0;
        end
        if (cmd.sum) begin
            neg_reg  <= dvd[DW-1];
            quo_reg  <= dvd[DW-1] ? unsigned'(-dvd) : unsigned'(dvd);
            rem_reg  <= '0;
            dcnt_reg <= '0;
            dvs_reg  <= (mode_reg inside {sta_pkg::MODE_EXP_MSQ, sta_pkg::MODE_EXP_AVG}) ?
                        h_eff : count;
        end
        if (cmd.div_step) begin
            rem_reg  <= rem_ge ? rem_try - {1'b0, dvs_reg} : rem_try;
            quo_reg  <= {quo_reg[DW-2:0], rem_ge};
            dcnt_reg <= dcnt_reg + sta_pkg::DCNT_W'(1);
        end
        if (cmd.div_out) begin
            res_reg <= neg_reg ? -signed'(quo_reg[31:0]) : signed'(quo_reg[31:0]);
        end
        if (cmd.scan_cmp) begin
            best_reg <= best_next;
            res_reg  <= 32'(best_next);
            j_reg    <= j_reg + SW'(1);
        end
        if (cmd.finish) begin
            m_data_reg.bin_index   <= 10'(pos_reg);
            m_data_reg.trace_value <= res_reg;
            m_data_reg.last_bin    <= last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    sta_ram #(.WIDTH(32), .DEPTH(2 ** PW)) u_result_ram (
        .aclk  (aclk),
        .we    (cmd.finish),
        .waddr (pos_reg),
        .wdata (res_reg),
        .raddr (pos_reg),
        .rdata (res_rdata)
    );

    sta_ram #(.WIDTH(SUMW), .DEPTH(2 ** PW)) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (pos_reg),
        .wdata (dvd[SUMW-1:0]),
        .raddr (pos_reg),
        .rdata (sum_rdata)
    );

    sta_ram #(.WIDTH(16), .DEPTH(2 ** (SW + PW))) u_ring_ram (
        .aclk  (aclk),
        .we    (cmd.finish),
        .waddr (ring_waddr),
        .wdata (x_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

endmodule
`default_nettype wire

/* design/spectrum_trace_averager.sv */
// Hold modes pass READ, EVAL and FINISH; divided modes add SUM, the 48-step serial divider and DIVOUT;
// a window rescan repeats SCAN_RD and SCAN_CMP for each history slot on the ring memory port.
// Throughput: one item at a time; FINISH also waits while the output holds an unaccepted result.
// A clear request is taken while idle and gives no result.
// Reset (aresetn low, synchronous) restores the configuration and counter registers and empties averaging state;
// stores need no clearing pass, their reads are masked by the frame count.
`default_nettype none
`include "spectrum_trace_averager_assert.svh"
module spectrum_trace_averager #(
    parameter int BINS_MAX    = 1024,
    parameter int HISTORY_MAX = 256
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_we,
    input  wire  [1:0]                cfg_index,
    input  wire  [sta_pkg::CFG_W-1:0] cfg_wdata,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  sta_pkg::in_item_t         s_payload,
    output logic                      m_valid,
    input  wire                       m_ready,
    output sta_pkg::out_item_t        m_payload
);

    sta_pkg::cmd_t    cmd;
    sta_pkg::status_t status;

    sta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_payload.kind),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    sta_dpath #(.BINS_MAX(BINS_MAX), .HISTORY_MAX(HISTORY_MAX)) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_payload (s_payload),
        .cmd       (cmd),
        .m_ready   (m_ready),
        .status    (status),
        .m_valid   (m_valid),
        .m_payload (m_payload)
    );

    `STA_ASSERT_NEXT(a_sample_busy, s_valid && s_ready && !s_payload.kind, !s_ready)
    `STA_ASSERT_NEXT(a_clear_stays_ready, s_valid && s_ready && s_payload.kind, s_ready)
    `STA_ASSERT_NOW(a_result_from_finish, $rose(m_valid), $past(cmd.finish))

endmodule
`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the spectrum trace averager with its own trace predictor.
module tb;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int DRAIN_CYCLES = 600;
    localparam int NBINS        = 1024;
    localparam int NHIST        = 256;
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [1:0]                cfg_index = sta_pkg::REG_MODE;
    logic [sta_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    sta_pkg::in_item_t         s_payload = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b1;
    sta_pkg::out_item_t        m_payload;

    spectrum_trace_averager u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #10 aclk = ~aclk;

    // Predictor state.
    logic [2:0]  cur_mode    = sta_pkg::MODE_MOV_AVG;
    logic [10:0] cur_bins    = 11'd1024;
    logic [8:0]  cur_hist    = 9'd1;
    int          bin_pos     = 0;
    int          frames_held = 0;
    int          slot        = 0;
    int          trace_mem [NBINS];
    longint      sum_mem [NBINS];
    shortint     ring_mem [NHIST*NBINS];

    sta_pkg::out_item_t trace_q [$];
    int          mismatches  = 0;
    int          send_idle   = 0;
    int          recv_stall  = 0;
    int          cycles      = 0;

    function automatic int bins_eff();
        return (cur_bins < 1) ? 1 : (cur_bins > NBINS) ? NBINS : int'(cur_bins);
    endfunction

    function automatic int hist_eff();
        return (cur_hist < 1) ? 1 : (cur_hist > NHIST) ? NHIST : int'(cur_hist);
    endfunction

    function automatic void clear_trace();
        bin_pos = 0;
        frames_held = 0;
        slot = 0;
        foreach (sum_mem[i]) sum_mem[i] = 0;
    endfunction

    // Applies one request to the predictor and queues the result it gives, if any.
    function automatic void update_trace(sta_pkg::in_item_t it);
        int f, h, pos, idx, cnt, x, prev, old, res, j, v;
        bit first, full, want_max;
        longint sq;
        sta_pkg::out_item_t r;
        f = bins_eff();
        h = hist_eff();
        if (it.kind == sta_pkg::KIND_CLEAR) begin
            clear_trace();
            return;
        end
        x = int'(it.sample);
        pos = (bin_pos >= f) ? f - 1 : bin_pos;
        idx = slot * NBINS + pos;
        first = (frames_held == 0);
        full = (frames_held >= h);
        prev = trace_mem[pos];
        old = int'(ring_mem[idx]);
        sq = longint'(x) * longint'(x);
        cnt = full ? h : frames_held + 1;
        case (cur_mode)
            sta_pkg::MODE_PEAK: res = (first || x > prev) ? x : prev;
            sta_pkg::MODE_MIN: res = (first || x < prev) ? x : prev;
            sta_pkg::MODE_EXP_MSQ: res = first ? int'(sq)
                : int'((sq + longint'(h - 1) * longint'(prev)) / longint'(h));
            sta_pkg::MODE_EXP_AVG: res = first ? x
                : int'((longint'(x) + longint'(h - 1) * longint'(prev)) / longint'(h));
            sta_pkg::MODE_WIN_PEAK, sta_pkg::MODE_WIN_MIN: begin
                want_max = (cur_mode == sta_pkg::MODE_WIN_PEAK);
                if (first || h == 1) begin
                    res = x;
                end else begin
                    res = prev;
                    if (want_max ? (x > res) : (x < res)) res = x;
                    // The outgoing frame held the extreme, so look again without it.
                    if (full && old == res) begin
                        res = x;
                        for (j = 0; j < h; j++) begin
                            if (j == slot) continue;
                            v = int'(ring_mem[j * NBINS + pos]);
                            if (want_max ? (v > res) : (v < res)) res = v;
                        end
                    end
                end
            end
            sta_pkg::MODE_MOV_MSQ: begin
                if (full) sum_mem[pos] -= longint'(old) * longint'(old);
                sum_mem[pos] += sq;
                res = int'(sum_mem[pos] / longint'(cnt));
            end
            default: begin
                if (full) sum_mem[pos] -= longint'(old);
                sum_mem[pos] += longint'(x);
                res = int'(sum_mem[pos] / longint'(cnt));
            end
        endcase
        trace_mem[pos] = res;
        ring_mem[idx] = shortint'(x);
        r.bin_index = pos[9:0];
        r.trace_value = res;
        r.last_bin = (pos + 1 >= f);
        trace_q.push_back(r);
        if (r.last_bin) begin
            bin_pos = 0;
            if (frames_held < h) frames_held++;
            slot = (slot + 1) % h;
        end else begin
            bin_pos = pos + 1;
        end
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        sta_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (trace_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bin %0d value %0d last %0b",
                             m_payload.bin_index, m_payload.trace_value, m_payload.last_bin);
            end else begin
                e = trace_q.pop_front();
                if (m_payload !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 e.bin_index, e.trace_value, e.last_bin,
                                 m_payload.bin_index, m_payload.trace_value,
                                 m_payload.last_bin);
                end
            end
        end
    end

    task automatic send_item(logic kind, logic signed [15:0] sample);
        sta_pkg::in_item_t it;
        it.kind = kind;
        it.sample = sample;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        update_trace(it);
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds off until every pending result is in, then lets a result-free request finish.
    task automatic wait_idle();
        s_valid <= 1'b0;
        cfg_we <= 1'b0;
        while (trace_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[sta_pkg::CFG_W-1:0];
        @(posedge aclk);
        case (idx)
            sta_pkg::REG_MODE: cur_mode = val[2:0];
            sta_pkg::REG_FRAME_BINS: cur_bins = val[10:0];
            sta_pkg::REG_HISTORY_LEN: cur_hist = val[8:0];
            default: return;
        endcase
        clear_trace();
    endtask

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 10) return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        if (r < 50) return 16'($urandom_range(16) - 8);
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        int m;
        for (m = 0; m < 8; m++) begin
            write_reg(sta_pkg::REG_MODE, m);
            write_reg(sta_pkg::REG_FRAME_BINS, 1);
            write_reg(sta_pkg::REG_HISTORY_LEN, 2);
            // Third sample drops the first frame's extreme out of the window.
            if (m % 2 == 1) begin
                send_item(sta_pkg::KIND_SAMPLE, 16'sh8000);
                send_item(sta_pkg::KIND_SAMPLE, 16'sh7fff);
            end else begin
                send_item(sta_pkg::KIND_SAMPLE, 16'sh7fff);
                send_item(sta_pkg::KIND_SAMPLE, 16'sh8000);
            end
            send_item(sta_pkg::KIND_SAMPLE, -16'sd1);
            if (m == 3) send_item(sta_pkg::KIND_CLEAR, 16'sh7fff);
            wait_idle();
        end
        write_reg(REG_SPARE, 0);
        send_item(sta_pkg::KIND_SAMPLE, 16'sd0);
        wait_idle();
    endtask

    task automatic test_full_frame();
        int i;
        write_reg(sta_pkg::REG_MODE, sta_pkg::MODE_PEAK);
        write_reg(sta_pkg::REG_FRAME_BINS, 2047);
        write_reg(sta_pkg::REG_HISTORY_LEN, 0);
        for (i = 0; i < 1030; i++) send_item(sta_pkg::KIND_SAMPLE, pick_sample());
        wait_idle();
    endtask

    task automatic test_deep_window();
        int i;
        write_reg(sta_pkg::REG_MODE,
                  $urandom_range(1) ? sta_pkg::MODE_WIN_PEAK : sta_pkg::MODE_WIN_MIN);
        write_reg(sta_pkg::REG_FRAME_BINS, 0);
        write_reg(sta_pkg::REG_HISTORY_LEN, 511);
        for (i = 0; i < 300; i++) send_item(sta_pkg::KIND_SAMPLE, pick_sample());
        wait_idle();
        write_reg(sta_pkg::REG_MODE, sta_pkg::MODE_MOV_MSQ);
        write_reg(sta_pkg::REG_HISTORY_LEN, 256);
        for (i = 0; i < 20; i++) send_item(sta_pkg::KIND_SAMPLE, pick_sample());
        wait_idle();
    endtask

    task automatic test_random(int idle, int stall, int n_samples);
        int sent, r, fb, hl, n, i;
        send_idle = idle;
        recv_stall = stall;
        sent = 0;
        while (sent < n_samples) begin
            r = $urandom_range(99);
            fb = (r < 4) ? 0 : (r < 6) ? 2047 : (r < 9) ? $urandom_range(9, 1024)
                : $urandom_range(1, 8);
            r = $urandom_range(99);
            hl = (r < 4) ? 0 : (r < 6) ? 511 : (r < 9) ? $urandom_range(9, 256)
                : $urandom_range(1, 8);
            write_reg(sta_pkg::REG_MODE, $urandom_range(7));
            write_reg(sta_pkg::REG_FRAME_BINS, fb);
            write_reg(sta_pkg::REG_HISTORY_LEN, hl);
            if ($urandom_range(9) == 0) write_reg(REG_SPARE, $urandom_range(2047));
            n = bins_eff() * $urandom_range(1, hist_eff() + 3);
            if (n > 48) n = 48;
            for (i = 0; i < n; i++) begin
                if ($urandom_range(99) < 4) send_item(sta_pkg::KIND_CLEAR, 16'($urandom));
                send_item(sta_pkg::KIND_SAMPLE, pick_sample());
                sent++;
            end
            wait_idle();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_frame();
        test_deep_window();
        test_random(0, 0, 100);
        test_random(83, 0, 100);
        test_random(0, 83, 100);
        test_random(31, 31, 100);
        wait_idle();
        if (mismatches == 0 && trace_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/sta_pkg.sv
design/sta_ram.sv
design/sta_ctrl.sv
design/sta_dpath.sv
design/spectrum_trace_averager.sv
sim/tb.sv
